[src/bts_pkg.sv]
// Shared types, constants and functions of the bilinear texture sampler.
// The sRGB decode table is built here at elaboration time.
// Depends on nothing; every other file imports this package.
package bts_pkg;

    localparam int TEX_DIM    = 256;
    localparam int IDX_W      = $clog2(TEX_DIM);
    localparam int HALF_W     = (IDX_W > 1) ? IDX_W - 1 : 1;
    localparam int BANK_DEPTH = 1 << (2 * HALF_W);
    localparam int SZ_W       = $clog2(TEX_DIM + 1);
    localparam int COORD_W    = 24;
    localparam int FRAC_W     = 16;
    localparam int INT_SHIFT  = COORD_W - FRAC_W - 1;
    localparam int PROD_W     = COORD_W + SZ_W;
    localparam int V_W        = PROD_W - FRAC_W;
    localparam int REM_SPLIT  = (INT_SHIFT + 1) / 2;
    localparam int Q_DEPTH    = 8;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int CNT_W      = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_ON = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_BLUE  = 3'd5;

    localparam longint unsigned SRGB_DEN = 64'd269025;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_SAMPLE,
        KIND_FLAT
    } kind_t;

    typedef struct packed {
        logic        texture_on;
        logic [8:0]  tex_width;
        logic [8:0]  tex_height;
        logic [15:0] flat_red;
        logic [15:0] flat_green;
        logic [15:0] flat_blue;
    } cfg_regs_t;

    typedef struct packed {
        kind_t             kind;
        logic [IDX_W-1:0]  col_a;
        logic [IDX_W-1:0]  col_b;
        logic [IDX_W-1:0]  row_a;
        logic [IDX_W-1:0]  row_b;
        logic [15:0]       fx;
        logic [15:0]       fy;
        logic [23:0]       rgb;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } q_status_t;

    typedef logic [15:0] rom_t [256];

    // Integer sRGB-to-linear decode in Q2.30, rounded to Q0.16.
    function automatic rom_t build_decode_rom();
        rom_t rom;
        logic [63:0] a, x, x2, lo, hi, mid, p, y, o;
        for (int n = 0; n < 256; n++) begin
            if (n <= 10) begin
                o = (64'(n) * 64'd6553600 + 64'd164730) / 64'd329460;
            end else begin
                a  = 64'(n) * 64'd1000 + 64'd14025;
                x  = ((a << 30) + SRGB_DEN / 2) / SRGB_DEN;
                x2 = (x * x) >> 30;
                lo = 64'd0;
                hi = 64'd1 << 30;
                while (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    p = mid;
                    for (int k = 0; k < 4; k++) begin
                        p = (p * mid) >> 30;
                    end
                    if (p <= x2) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
                y = (x2 * lo) >> 30;
                o = (y + 64'd8192) >> 14;
                if (o > 64'd65535) begin
                    o = 64'd65535;
                end
            end
            rom[n] = o[15:0];
        end
        return rom;
    endfunction

    localparam rom_t DECODE_ROM = build_decode_rom();

    // Size in use: zero acts as one, anything above the store saturates.
    function automatic logic [SZ_W-1:0] eff_size(input logic [8:0] v);
        if (v == 9'd0) begin
            return SZ_W'(1);
        end
        if (int'(v) > TEX_DIM) begin
            return SZ_W'(TEX_DIM);
        end
        return SZ_W'(v);
    endfunction

    // Restoring remainder steps from shift hi down to shift lo.
    function automatic logic [V_W-1:0] rem_steps(input logic [V_W-1:0] v,
                                                  input logic [SZ_W-1:0] size,
                                                  input int hi, input int lo);
        logic [V_W-1:0] r;
        logic [V_W-1:0] d;
        r = v;
        for (int k = hi; k >= lo; k--) begin
            d = V_W'(size) << k;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r;
    endfunction

endpackage

[src/bts_if.sv]
// Channel interfaces of the texture sampler: input, result and config words.
// Depends on bts_pkg for widths.
interface bts_in_if import bts_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [7:0]                texel_col;
    logic [7:0]                texel_row;
    logic [7:0]                in_red;
    logic [7:0]                in_green;
    logic [7:0]                in_blue;
    logic signed [COORD_W-1:0] coord_s;
    logic signed [COORD_W-1:0] coord_t;

    modport source (output valid, op, texel_col, texel_row, in_red, in_green,
                    in_blue, coord_s, coord_t, input ready);
    modport sink (input valid, op, texel_col, texel_row, in_red, in_green,
                  in_blue, coord_s, coord_t, output ready);
endinterface

interface bts_out_if import bts_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] lin_red;
    logic [15:0] lin_green;
    logic [15:0] lin_blue;

    modport source (output valid, lin_red, lin_green, lin_blue, input ready);
    modport sink (input valid, lin_red, lin_green, lin_blue, output ready);
endinterface

interface bts_cfg_if import bts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/bts_front.sv]
// Front end: accepts words, classifies them and locates the texel footprint.
// Depends on bts_pkg and bts_in_if.
module bts_front import bts_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    bts_in_if.sink    in_ch,
    input  cfg_regs_t cfg,
    input  q_status_t q_status,
    output logic      push,
    output cmd_t      push_cmd
);

    logic [SZ_W-1:0]  size_w;
    logic [SZ_W-1:0]  size_h;
    logic [CNT_W-1:0] in_flight;
    logic             accept;
    logic             in_store;
    logic             s1_valid_next;
    kind_t            s1_kind_next;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    kind_t s1_kind_reg, s2_kind_reg, s3_kind_reg, s4_kind_reg, s5_kind_reg;
    logic [IDX_W-1:0] s1_col_reg, s2_col_reg, s3_col_reg, s4_col_reg, s5_col_reg;
    logic [IDX_W-1:0] s1_row_reg, s2_row_reg, s3_row_reg, s4_row_reg, s5_row_reg;
    logic [23:0] s1_rgb_reg, s2_rgb_reg, s3_rgb_reg, s4_rgb_reg, s5_rgb_reg;
    logic signed [COORD_W-1:0] s1_cs_reg, s1_ct_reg;
    logic signed [PROD_W-1:0]  s2_ps_reg, s2_pt_reg;
    logic [V_W-1:0] s3_vs_reg, s3_vt_reg, s4_vs_reg, s4_vt_reg, s5_vs_reg, s5_vt_reg;
    logic [15:0] s3_fx_reg, s3_fy_reg, s4_fx_reg, s4_fy_reg, s5_fx_reg, s5_fy_reg;

    logic signed [PROD_W-1:0] prod_s_next;
    logic signed [PROD_W-1:0] prod_t_next;
    logic [V_W-1:0]           vs_next;
    logic [V_W-1:0]           vt_next;
    logic [IDX_W-1:0]         base_s;
    logic [IDX_W-1:0]         base_t;
    logic [IDX_W-1:0]         next_s;
    logic [IDX_W-1:0]         next_t;

    assign size_w = eff_size(cfg.tex_width);
    assign size_h = eff_size(cfg.tex_height);

    // Credits: words in the front pipeline plus queue occupancy never exceed the queue.
    assign in_flight = CNT_W'(s1_valid_reg) + CNT_W'(s2_valid_reg) + CNT_W'(s3_valid_reg)
                     + CNT_W'(s4_valid_reg) + CNT_W'(s5_valid_reg) + q_status.count;
    assign in_ch.ready = (in_flight < CNT_W'(Q_DEPTH));
    assign accept = in_ch.valid && in_ch.ready;

    assign in_store = (int'(in_ch.texel_col) < TEX_DIM) && (int'(in_ch.texel_row) < TEX_DIM);

    always_comb
    begin
        if (in_ch.op == OP_WRITE) begin
            s1_kind_next  = KIND_WRITE;
            s1_valid_next = accept && in_store;
        end else begin
            s1_kind_next  = cfg.texture_on ? KIND_SAMPLE : KIND_FLAT;
            s1_valid_next = accept;
        end
    end

    assign prod_s_next = PROD_W'(s1_cs_reg) * signed'(PROD_W'(size_w));
    assign prod_t_next = PROD_W'(s1_ct_reg) * signed'(PROD_W'(size_h));

    // Floor index plus a bias of a whole number of sizes keeps it non-negative.
    assign vs_next = V_W'(s2_ps_reg[PROD_W-1:FRAC_W]) + (V_W'(size_w) << INT_SHIFT);
    assign vt_next = V_W'(s2_pt_reg[PROD_W-1:FRAC_W]) + (V_W'(size_h) << INT_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= s1_kind_next;
        s1_col_reg  <= IDX_W'(in_ch.texel_col);
        s1_row_reg  <= IDX_W'(in_ch.texel_row);
        s1_rgb_reg  <= {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
        s1_cs_reg   <= in_ch.coord_s;
        s1_ct_reg   <= in_ch.coord_t;

        s2_kind_reg <= s1_kind_reg;
        s2_col_reg  <= s1_col_reg;
        s2_row_reg  <= s1_row_reg;
        s2_rgb_reg  <= s1_rgb_reg;
        s2_ps_reg   <= prod_s_next;
        s2_pt_reg   <= prod_t_next;

        s3_kind_reg <= s2_kind_reg;
        s3_col_reg  <= s2_col_reg;
        s3_row_reg  <= s2_row_reg;
        s3_rgb_reg  <= s2_rgb_reg;
        s3_vs_reg   <= vs_next;
        s3_vt_reg   <= vt_next;
        s3_fx_reg   <= s2_ps_reg[FRAC_W-1:0];
        s3_fy_reg   <= s2_pt_reg[FRAC_W-1:0];

        s4_kind_reg <= s3_kind_reg;
        s4_col_reg  <= s3_col_reg;
        s4_row_reg  <= s3_row_reg;
        s4_rgb_reg  <= s3_rgb_reg;
        s4_vs_reg   <= rem_steps(s3_vs_reg, size_w, INT_SHIFT, REM_SPLIT);
        s4_vt_reg   <= rem_steps(s3_vt_reg, size_h, INT_SHIFT, REM_SPLIT);
        s4_fx_reg   <= s3_fx_reg;
        s4_fy_reg   <= s3_fy_reg;

        s5_kind_reg <= s4_kind_reg;
        s5_col_reg  <= s4_col_reg;
        s5_row_reg  <= s4_row_reg;
        s5_rgb_reg  <= s4_rgb_reg;
        s5_vs_reg   <= rem_steps(s4_vs_reg, size_w, REM_SPLIT - 1, 0);
        s5_vt_reg   <= rem_steps(s4_vt_reg, size_h, REM_SPLIT - 1, 0);
        s5_fx_reg   <= s4_fx_reg;
        s5_fy_reg   <= s4_fy_reg;
    end

    // The right and lower neighbors clamp at the last column and row.
    assign base_s = IDX_W'(s5_vs_reg);
    assign base_t = IDX_W'(s5_vt_reg);
    assign next_s = ((SZ_W'(base_s) + SZ_W'(1)) == size_w) ? base_s : IDX_W'(base_s + 1'b1);
    assign next_t = ((SZ_W'(base_t) + SZ_W'(1)) == size_h) ? base_t : IDX_W'(base_t + 1'b1);

    assign push = s5_valid_reg;

    always_comb
    begin
        push_cmd.kind = s5_kind_reg;
        push_cmd.fx   = s5_fx_reg;
        push_cmd.fy   = s5_fy_reg;
        push_cmd.rgb  = s5_rgb_reg;
        if (s5_kind_reg == KIND_WRITE) begin
            push_cmd.col_a = s5_col_reg;
            push_cmd.col_b = s5_col_reg;
            push_cmd.row_a = s5_row_reg;
            push_cmd.row_b = s5_row_reg;
        end else begin
            push_cmd.col_a = base_s;
            push_cmd.col_b = next_s;
            push_cmd.row_a = base_t;
            push_cmd.row_b = next_t;
        end
    end

endmodule

[src/bts_queue.sv]
// Command queue between the front end and the back end.
// Depends on bts_pkg.
module bts_queue import bts_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    cmd_t             slots_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head         = slots_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(Q_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= Q_AW'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= Q_AW'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow a push");

endmodule

[src/bts_back.sv]
// Back end: banked texel store, sRGB decode and bilinear blend pipeline.
// Depends on bts_pkg and bts_out_if.
module bts_back import bts_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  q_status_t q_status,
    output logic      pop,
    input  cfg_regs_t cfg,
    bts_out_if.source out_ch
);

    logic        en;
    logic [23:0] bank_rd [4];

    logic b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg, b5_valid_reg;
    kind_t b1_kind_reg, b2_kind_reg, b3_kind_reg, b4_kind_reg, b5_kind_reg;
    logic [15:0] b1_fx_reg, b2_fx_reg, b3_fx_reg, b4_fx_reg;
    logic [15:0] b1_fy_reg, b2_fy_reg;
    logic [3:0]  b1_par_reg;

    logic [15:0] b2_lin_reg [4][3];
    logic [32:0] b3_q_reg   [4][3];
    logic [32:0] b4_a_reg   [3];
    logic [32:0] b4_b_reg   [3];
    logic [49:0] b5_ma_reg  [3];
    logic [49:0] b5_mb_reg  [3];

    logic [23:0] corner [4];
    logic [15:0] lin_next [4][3];
    logic [16:0] gy2;
    logic [16:0] gx4;
    logic [49:0] total [3];

    logic        out_valid_reg;
    logic [15:0] out_red_reg;
    logic [15:0] out_green_reg;
    logic [15:0] out_blue_reg;

    assign en  = !out_valid_reg || out_ch.ready;
    assign pop = en && !q_status.empty;

    // Four banks split by row and column parity: a footprint touches each at most once.
    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        localparam logic [1:0] BANK_ID = 2'(gb);
        logic [23:0]             bank_mem [BANK_DEPTH];
        logic [23:0]             rd_reg;
        logic [IDX_W-1:0]        rcol;
        logic [IDX_W-1:0]        rrow;
        logic [2*HALF_W-1:0]     addr;
        logic                    wr_here;

        assign rcol = (head.col_a[0] == BANK_ID[0]) ? head.col_a : head.col_b;
        assign rrow = (head.row_a[0] == BANK_ID[1]) ? head.row_a : head.row_b;
        assign addr = {HALF_W'(rrow >> 1), HALF_W'(rcol >> 1)};
        assign wr_here = pop && (head.kind == KIND_WRITE)
                      && ({head.row_a[0], head.col_a[0]} == BANK_ID);

        always_ff @(posedge clk)
        begin
            if (wr_here) begin
                bank_mem[addr] <= head.rgb;
            end
            if (pop) begin
                rd_reg <= bank_mem[addr];
            end
        end

        assign bank_rd[gb] = rd_reg;
    end

    // Corners: 0 is (j1,i1), 1 is (j2,i1), 2 is (j1,i2), 3 is (j2,i2).
    assign corner[0] = bank_rd[{b1_par_reg[2], b1_par_reg[0]}];
    assign corner[1] = bank_rd[{b1_par_reg[3], b1_par_reg[0]}];
    assign corner[2] = bank_rd[{b1_par_reg[2], b1_par_reg[1]}];
    assign corner[3] = bank_rd[{b1_par_reg[3], b1_par_reg[1]}];

    always_comb
    begin
        for (int c = 0; c < 4; c++) begin
            for (int ch = 0; ch < 3; ch++) begin
                lin_next[c][ch] = DECODE_ROM[corner[c][8*(2-ch) +: 8]];
            end
        end
    end

    assign gy2 = 17'h10000 - 17'(b2_fy_reg);
    assign gx4 = 17'h10000 - 17'(b4_fx_reg);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++) begin
            total[ch] = b5_ma_reg[ch] + b5_mb_reg[ch] + (50'd1 << 31);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            b1_valid_reg  <= pop;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            b5_valid_reg  <= b4_valid_reg;
            out_valid_reg <= b5_valid_reg && (b5_kind_reg != KIND_WRITE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            b1_kind_reg <= head.kind;
            b1_fx_reg   <= head.fx;
            b1_fy_reg   <= head.fy;
            b1_par_reg  <= {head.row_b[0], head.row_a[0], head.col_b[0], head.col_a[0]};

            b2_kind_reg <= b1_kind_reg;
            b2_fx_reg   <= b1_fx_reg;
            b2_fy_reg   <= b1_fy_reg;
            b2_lin_reg  <= lin_next;

            b3_kind_reg <= b2_kind_reg;
            b3_fx_reg   <= b2_fx_reg;
            for (int ch = 0; ch < 3; ch++) begin
                b3_q_reg[0][ch] <= 33'(b2_lin_reg[0][ch]) * 33'(gy2);
                b3_q_reg[1][ch] <= 33'(b2_lin_reg[1][ch]) * 33'(b2_fy_reg);
                b3_q_reg[2][ch] <= 33'(b2_lin_reg[2][ch]) * 33'(gy2);
                b3_q_reg[3][ch] <= 33'(b2_lin_reg[3][ch]) * 33'(b2_fy_reg);
            end

            b4_kind_reg <= b3_kind_reg;
            b4_fx_reg   <= b3_fx_reg;
            for (int ch = 0; ch < 3; ch++) begin
                b4_a_reg[ch] <= b3_q_reg[0][ch] + b3_q_reg[1][ch];
                b4_b_reg[ch] <= b3_q_reg[2][ch] + b3_q_reg[3][ch];
            end

            b5_kind_reg <= b4_kind_reg;
            for (int ch = 0; ch < 3; ch++) begin
                b5_ma_reg[ch] <= 50'(b4_a_reg[ch]) * 50'(gx4);
                b5_mb_reg[ch] <= 50'(b4_b_reg[ch]) * 50'(b4_fx_reg);
            end

            if (b5_kind_reg == KIND_FLAT) begin
                out_red_reg   <= cfg.flat_red;
                out_green_reg <= cfg.flat_green;
                out_blue_reg  <= cfg.flat_blue;
            end else begin
                out_red_reg   <= total[0][47:32];
                out_green_reg <= total[1][47:32];
                out_blue_reg  <= total[2][47:32];
            end
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.lin_red   = out_red_reg;
    assign out_ch.lin_green = out_green_reg;
    assign out_ch.lin_blue  = out_blue_reg;

endmodule

[src/bilinear_texture_sampler_core.sv]
// Top level of the bilinear texture sampler: config registers and the
// front end, command queue and back end. Depends on bts_pkg and bts_if.
//
//  Channel   Dir   Word carried
//  in_ch     in    op, texel_col/row, in_red/green/blue, coord_s/t (Q8.16)
//  out_ch    out   lin_red, lin_green, lin_blue (Q0.16), one per sample
//  cfg       in    index, data: register write, always ready
//
// One word is accepted per cycle while credits remain. A sample's result passes
// through five front stages (input register, multiply, bias, two remainder
// stages), the queue and six back stages (bank read, decode, multiply, sum,
// multiply, output register) before it is valid.
// Reset clears control state only; the texel store is not cleared.
// A stalled output holds the whole back end; the front keeps running into
// the queue and stops accepting words once its credits are used up.
//
// The front end scales each coordinate by the size in use, takes the floor
// and reduces it modulo the size with a pipelined restoring remainder. Write
// words and samples then go through the queue in order, so a sample always
// sees exactly the texels written before it. The store is split into four
// banks by row and column parity; the four texels of a footprint, or fewer
// where the neighbors clamp, land in distinct banks and are read in the same
// cycle. The blend is done separably in y then x, which forms the same
// exact sum as the four-weight form before rounding.
module bilinear_texture_sampler_core import bts_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    bts_in_if.sink    in_ch,
    bts_out_if.source out_ch,
    bts_cfg_if.sink   cfg
);

    cfg_regs_t cfg_reg;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;
    q_status_t q_status;

    assign cfg.ready = 1'b1;

    // Config words must arrive only while the sampler is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.texture_on <= 1'b0;
            cfg_reg.tex_width  <= 9'd256;
            cfg_reg.tex_height <= 9'd256;
            cfg_reg.flat_red   <= 16'd0;
            cfg_reg.flat_green <= 16'd0;
            cfg_reg.flat_blue  <= 16'd0;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                CFG_TEXTURE_ON: cfg_reg.texture_on <= cfg.data[0];
                CFG_TEX_WIDTH:  cfg_reg.tex_width  <= cfg.data[8:0];
                CFG_TEX_HEIGHT: cfg_reg.tex_height <= cfg.data[8:0];
                CFG_FLAT_RED:   cfg_reg.flat_red   <= cfg.data;
                CFG_FLAT_GREEN: cfg_reg.flat_green <= cfg.data;
                CFG_FLAT_BLUE:  cfg_reg.flat_blue  <= cfg.data;
                default:        ;
            endcase
        end
    end

    bts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    bts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    bts_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .cfg      (cfg_reg),
        .out_ch   (out_ch)
    );

endmodule

[sim/tb_bilinear_texture_sampler_core.sv]
// Self-checking testbench of bilinear_texture_sampler_core: texel loads, flat
// color, extreme sizes, random sampling and long output stalls.
// Depends on bts_pkg, bts_if and the core RTL.
`timescale 1ns / 100ps

module tb_bilinear_texture_sampler_core;
    import bts_pkg::*;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } color_t;

    logic clk;
    logic rst_n;

    bts_in_if  in_ch ();
    bts_out_if out_ch ();
    bts_cfg_if cfg ();

    bilinear_texture_sampler_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // The testbench keeps its own copy of the registers and of the texel
    // store. Texel writes update it on acceptance, so samples see the store
    // exactly as the block does.
    logic        shadow_tex_on;
    logic [8:0]  shadow_width;
    logic [8:0]  shadow_height;
    color_t      shadow_flat;
    logic [23:0] texels [65536];
    bit          written [65536];
    logic [15:0] linear_lut [256];

    color_t pending_colors [$];

    int src_idle_pct;
    int snk_stall_pct;
    int hold_off;
    int mismatches;
    int samples_checked;
    int words_sent;
    int phase_no;

    always #5 clk = ~clk;

    // Truncated Q2.30 fifth power.
    function automatic longint unsigned pow5_q30(input longint unsigned r);
        longint unsigned p;
        p = r;
        repeat (4) p = (p * r) >> 30;
        return p;
    endfunction

    // sRGB byte to linear Q0.16; the fifth root is found bit by bit, which
    // gives the largest root since the truncated power never decreases.
    function automatic logic [15:0] decode_srgb_byte(input int n);
        longint unsigned a, x, x2, root, cand, y, o;
        if (n <= 10) begin
            o = (longint'(n) * 6553600 + 164730) / 329460;
            return o[15:0];
        end
        a  = longint'(n) * 1000 + 14025;
        x  = ((a << 30) + 134512) / 269025;
        x2 = (x * x) >> 30;
        root = 0;
        for (int b = 30; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand <= (64'd1 << 30) && pow5_q30(cand) <= x2) begin
                root = cand;
            end
        end
        y = (x2 * root) >> 30;
        o = (y + 8192) >> 14;
        if (o > 65535) begin
            o = 65535;
        end
        return o[15:0];
    endfunction

    function automatic int size_in_use(input logic [8:0] v);
        if (v == 0) begin
            return 1;
        end
        if (v > 256) begin
            return 256;
        end
        return int'(v);
    endfunction

    // Floor of coordinate times size, wrapped; next index clamps at the edge.
    function automatic void find_footprint(input logic signed [23:0] coord,
                                           input int size,
                                           output int base, output int next,
                                           output longint unsigned frac);
        longint prod;
        longint fl;
        prod = longint'(coord) * size;
        fl   = prod >>> 16;
        frac = prod & 64'hFFFF;
        base = int'(fl % size);
        if (base < 0) begin
            base += size;
        end
        next = (base + 1 == size) ? base : base + 1;
    endfunction

    function automatic logic [15:0] mix4(input logic [15:0] l00, l01, l10, l11,
                                         input longint unsigned fx, fy);
        longint unsigned gx, gy, acc;
        gx  = 65536 - fx;
        gy  = 65536 - fy;
        acc = l00 * (gx * gy) + l01 * (gx * fy) + l10 * (fx * gy) + l11 * (fx * fy);
        return 16'((acc + (64'd1 << 31)) >> 32);
    endfunction

    function automatic color_t filtered_color(input logic signed [23:0] s,
                                              input logic signed [23:0] t);
        int i1, i2, j1, j2;
        longint unsigned fx, fy;
        logic [23:0] t00, t01, t10, t11;
        color_t c;
        if (!shadow_tex_on) begin
            return shadow_flat;
        end
        find_footprint(s, size_in_use(shadow_width), i1, i2, fx);
        find_footprint(t, size_in_use(shadow_height), j1, j2, fy);
        t00 = texels[j1 * 256 + i1];
        t01 = texels[j2 * 256 + i1];
        t10 = texels[j1 * 256 + i2];
        t11 = texels[j2 * 256 + i2];
        c.red   = mix4(linear_lut[t00[23:16]], linear_lut[t01[23:16]],
                       linear_lut[t10[23:16]], linear_lut[t11[23:16]], fx, fy);
        c.green = mix4(linear_lut[t00[15:8]], linear_lut[t01[15:8]],
                       linear_lut[t10[15:8]], linear_lut[t11[15:8]], fx, fy);
        c.blue  = mix4(linear_lut[t00[7:0]], linear_lut[t01[7:0]],
                       linear_lut[t10[7:0]], linear_lut[t11[7:0]], fx, fy);
        return c;
    endfunction

    // Sends one word; the prediction is made at the edge where it is taken.
    task automatic send_word(input logic op, input logic [7:0] col, row,
                             input logic [23:0] rgb,
                             input logic signed [23:0] s, t);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.op        = op;
        in_ch.texel_col = col;
        in_ch.texel_row = row;
        in_ch.in_red    = rgb[23:16];
        in_ch.in_green  = rgb[15:8];
        in_ch.in_blue   = rgb[7:0];
        in_ch.coord_s   = s;
        in_ch.coord_t   = t;
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
        if (op == OP_WRITE) begin
            texels[{row, col}]  = rgb;
            written[{row, col}] = 1'b1;
        end else begin
            pending_colors.push_back(filtered_color(s, t));
        end
    endtask

    task automatic write_texel(input int col, input int row, input logic [23:0] rgb);
        send_word(OP_WRITE, 8'(col), 8'(row), rgb, 24'($urandom), 24'($urandom));
    endtask

    task automatic sample_at(input logic signed [23:0] s, input logic signed [23:0] t);
        send_word(OP_SAMPLE, 8'($urandom), 8'($urandom), 24'($urandom), s, t);
    endtask

    // Registers are only written with the pipeline empty. A write word gives
    // no result, so wait out the latency after the last sample comes back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_colors.size() != 0) begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = value;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            CFG_TEXTURE_ON: shadow_tex_on     = value[0];
            CFG_TEX_WIDTH:  shadow_width      = value[8:0];
            CFG_TEX_HEIGHT: shadow_height     = value[8:0];
            CFG_FLAT_RED:   shadow_flat.red   = value;
            CFG_FLAT_GREEN: shadow_flat.green = value;
            CFG_FLAT_BLUE:  shadow_flat.blue  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Each test starts by taking the next idling mode in turn.
    task automatic next_idle_mode();
        case (phase_no % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 86; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 86; end
            default: begin src_idle_pct = 24; snk_stall_pct = 24; end
        endcase
        phase_no++;
    endtask

    // Loads every texel of the area in use that was never written, so no
    // sample can touch an undefined entry.
    task automatic fill_area();
        int w, h;
        w = size_in_use(shadow_width);
        h = size_in_use(shadow_height);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (!written[r * 256 + c]) begin
                    write_texel(c, r, 24'($urandom));
                end
            end
        end
    endtask

    // Coordinates: fully random half of the time, else near zero or at the range ends.
    function automatic logic signed [23:0] pick_coord();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom_range(131071)) - 24'sd65536;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_flat_color();
        next_idle_mode();
        write_reg(CFG_TEXTURE_ON, 16'd0);
        write_reg(CFG_FLAT_RED, 16'hFFFF);
        write_reg(CFG_FLAT_GREEN, 16'h0000);
        write_reg(CFG_FLAT_BLUE, 16'h8001);
        sample_at(24'sh7FFFFF, 24'sh800000);
        // Texel writes with texturing off still land in the store.
        write_texel(0, 0, 24'hFFFFFF);
        write_texel(255, 255, 24'h000000);
        sample_at(24'sh000000, 24'shFFFFFF);
        write_reg(CFG_FLAT_RED, 16'h0000);
        write_reg(CFG_FLAT_GREEN, 16'hFFFF);
        write_reg(CFG_FLAT_BLUE, 16'h7FFE);
        sample_at(24'sh123456, 24'shABCDEF);
    endtask

    // One row of 256 texels: a width above the store saturates and a
    // height of zero acts as one.
    task automatic test_wide_strip();
        next_idle_mode();
        write_reg(CFG_TEXTURE_ON, 16'd1);
        write_reg(CFG_TEX_WIDTH, 16'd300);
        write_reg(CFG_TEX_HEIGHT, 16'd0);
        // The first texels hold the byte extremes and the linear segment.
        for (int c = 0; c < 12; c++) begin
            write_texel(c, 0, {8'(c), 8'(255 - c), 8'(c * 23)});
        end
        fill_area();
        sample_at(24'sh000000, 24'sh000000);
        sample_at(24'sh00FFFF, 24'sh7FFFFF);
        sample_at(24'sh800000, 24'sh800000);
        sample_at(24'shFFFFFF, 24'sh000001);
        sample_at(24'sh000001, 24'shFFFFFF);
        for (int k = 0; k < 40; k++) begin
            sample_at(pick_coord(), pick_coord());
        end
        write_reg(CFG_TEX_WIDTH, 16'd256);
        for (int k = 0; k < 20; k++) begin
            sample_at(pick_coord(), pick_coord());
        end
    endtask

    task automatic test_tall_strip();
        next_idle_mode();
        write_reg(CFG_TEX_WIDTH, 16'd1);
        write_reg(CFG_TEX_HEIGHT, 16'h01FF);
        fill_area();
        for (int k = 0; k < 60; k++) begin
            sample_at(pick_coord(), pick_coord());
        end
    endtask

    // Random sizes, mostly small, with writes and samples mixed so that
    // samples see freshly overwritten texels.
    task automatic test_random_sampling();
        int w, h, items;
        for (int round = 0; round < 12; round++) begin
            next_idle_mode();
            write_reg(CFG_TEXTURE_ON, 16'($urandom_range(7) != 0));
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            if ($urandom_range(5) == 0) begin
                w = $urandom_range(1) ? 0 : $urandom_range(256, 511);
                h = $urandom_range(2);
            end
            write_reg(CFG_TEX_WIDTH, 16'(w) | (16'($urandom) & 16'hFE00));
            write_reg(CFG_TEX_HEIGHT, 16'(h));
            write_reg(CFG_FLAT_RED, 16'($urandom));
            write_reg(CFG_FLAT_GREEN, 16'($urandom));
            write_reg(CFG_FLAT_BLUE, 16'($urandom));
            fill_area();
            w = size_in_use(shadow_width);
            h = size_in_use(shadow_height);
            items = 30;
            for (int k = 0; k < items; k++) begin
                case ($urandom_range(9))
                    0, 1, 2: write_texel($urandom_range(w - 1), $urandom_range(h - 1),
                                         24'($urandom));
                    3: write_texel($urandom_range(255), $urandom_range(255),
                                   24'($urandom));
                    default: sample_at(pick_coord(), pick_coord());
                endcase
            end
        end
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the queue fills and the input stalls.
    task automatic test_output_stall();
        next_idle_mode();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_reg(CFG_TEXTURE_ON, 16'd1);
        write_reg(CFG_TEX_WIDTH, 16'd8);
        write_reg(CFG_TEX_HEIGHT, 16'd8);
        fill_area();
        hold_off = 300;
        for (int k = 0; k < 80; k++) begin
            sample_at(pick_coord(), pick_coord());
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk) begin
        if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Result checker: each word taken is compared with the oldest prediction.
    always @(posedge clk) begin
        color_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word %h %h %h", out_ch.lin_red,
                             out_ch.lin_green, out_ch.lin_blue);
                end
            end else begin
                want = pending_colors.pop_front();
                samples_checked++;
                if (want.red !== out_ch.lin_red || want.green !== out_ch.lin_green
                    || want.blue !== out_ch.lin_blue) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("color mismatch: expected %h %h %h, got %h %h %h",
                                 want.red, want.green, want.blue, out_ch.lin_red,
                                 out_ch.lin_green, out_ch.lin_blue);
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", pending_colors.size());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int wait_cycles;
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_WRITE;
        in_ch.texel_col = '0;
        in_ch.texel_row = '0;
        in_ch.in_red = '0;
        in_ch.in_green = '0;
        in_ch.in_blue = '0;
        in_ch.coord_s = '0;
        in_ch.coord_t = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_TEXTURE_ON;
        cfg.data = '0;
        out_ch.ready = 1'b0;
        hold_off = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        mismatches = 0;
        samples_checked = 0;
        words_sent = 0;
        phase_no = 0;
        shadow_tex_on = 1'b0;
        shadow_width = 9'd256;
        shadow_height = 9'd256;
        shadow_flat = '{16'd0, 16'd0, 16'd0};
        for (int n = 0; n < 256; n++) begin
            linear_lut[n] = decode_srgb_byte(n);
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_flat_color();
        test_wide_strip();
        test_tall_strip();
        test_random_sampling();
        test_output_stall();

        @(negedge clk);
        in_ch.valid = 1'b0;
        wait_cycles = 0;
        while (pending_colors.size() != 0 && wait_cycles < 100000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (30) @(negedge clk);

        $display("Sent %0d words over flat color, strip and random sizes;", words_sent);
        $display("checked %0d filtered colors under stalls and idle gaps.",
                 samples_checked);
        if (mismatches == 0 && pending_colors.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_colors.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[bilinear_texture_sampler_core.f]
src/bts_pkg.sv
src/bts_if.sv
src/bts_front.sv
src/bts_queue.sv
src/bts_back.sv
src/bilinear_texture_sampler_core.sv
sim/tb_bilinear_texture_sampler_core.sv
